// ===== design/indexed_list_insert_erase_top_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_ERASE_TOP_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define ILIE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ILIE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ilie_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list package
// Capacity, widths, request codes and the input and result word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilie_pkg;

  // List capacity and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic                    ok;
    logic                    elem_valid;
    logic signed [VAL_W-1:0] elem_value;
    logic [COUNT_W-1:0]      count_now;
    logic                    last;
  } out_word_t;

  // Result word handed from the sequencer to the output register
  typedef struct packed {
    logic      ld;
    out_word_t word;
  } res_req_t;

endpackage

// ===== design/ilie_ram.sv =====
// ----------------------------------------------------------------------------
// Indexed list entry RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilie_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ilie_seq.sv =====
// ----------------------------------------------------------------------------
// Indexed list sequencer
// Checks each request, moves entries one at a time through the RAM using a
// shared index step unit, and builds result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_list_insert_erase_top_defines.svh"

module ilie_seq import ilie_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output logic [VAL_W-1:0] ram_wdata,
  output logic             ram_re,
  output logic [IDX_W-1:0] ram_raddr,
  input  logic [VAL_W-1:0] ram_rdata,
  input  logic             out_free,
  output res_req_t         res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_RESP,
    S_DRD,
    S_DEMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             ok_r, ok_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic [CMP_W-1:0] pos_u;
  logic [CMP_W-1:0] fill_c;
  logic             pos_neg;
  logic             ins_good;
  logic             era_good;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] fill_idx;
  logic [IDX_W-1:0] fill_m1;
  logic [IDX_W-1:0] step;
  logic [CNT_W-1:0] cnt_after;
  logic             dump_last;

  // Range checks on the incoming word
  assign pos_neg  = in_data.position[POS_W-1];
  assign pos_u    = CMP_W'($unsigned(in_data.position));
  assign fill_c   = CMP_W'(fill_r);
  assign ins_good = (fill_r < CNT_W'(CAPACITY)) && !pos_neg && (pos_u <= fill_c);
  assign era_good = (fill_r != '0) && !pos_neg && (pos_u < fill_c);
  assign pos_idx  = IDX_W'(in_data.position);
  assign fill_idx = IDX_W'(fill_r);
  assign fill_m1  = IDX_W'(fill_r - CNT_W'(1));

  // Shared index step: down for insert, up for erase and dump
  assign step = (kind_r == REQ_INSERT) ? (idx_r - IDX_W'(1)) : (idx_r + IDX_W'(1));

  // Entry count once this request completes
  always_comb begin
    cnt_after = fill_r;
    if (ok_r && (kind_r == REQ_INSERT)) begin
      cnt_after = fill_r + CNT_W'(1);
    end else if (ok_r && (kind_r == REQ_ERASE)) begin
      cnt_after = fill_r - CNT_W'(1);
    end
  end

  assign dump_last = (idx_r == end_r);
  assign in_stall  = (state_r != S_IDLE);

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    val_nxt   = val_r;
    ok_nxt    = ok_r;
    fill_nxt  = fill_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = step;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_data.req_type;
          val_nxt  = in_data.item_value;
          case (in_data.req_type)
            REQ_INSERT: begin
              ok_nxt  = ins_good;
              idx_nxt = fill_idx;
              end_nxt = pos_idx;
              if (!ins_good) begin
                state_nxt = S_RESP;
              end else if (fill_idx == pos_idx) begin
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_SH_RD;
              end
            end
            REQ_ERASE: begin
              ok_nxt  = era_good;
              idx_nxt = pos_idx;
              end_nxt = fill_m1;
              if (!era_good || (pos_idx == fill_m1)) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SH_RD;
              end
            end
            REQ_DUMP: begin
              ok_nxt  = 1'b1;
              idx_nxt = '0;
              end_nxt = fill_m1;
              state_nxt = (fill_r == '0) ? S_RESP : S_DRD;
            end
            default: begin
              ok_nxt    = 1'b0;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = step;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = step;
        if (step == end_r) begin
          state_nxt = (kind_r == REQ_INSERT) ? S_PUT : S_RESP;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = end_r;
        ram_wdata = val_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        res.word.ok        = ok_r;
        res.word.count_now = COUNT_W'(cnt_after);
        res.word.last      = 1'b1;
        if (out_free) begin
          res.ld    = 1'b1;
          fill_nxt  = cnt_after;
          state_nxt = S_IDLE;
        end
      end
      S_DRD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        res.word.ok         = 1'b1;
        res.word.elem_valid = 1'b1;
        res.word.elem_value = ram_rdata;
        res.word.count_now  = COUNT_W'(fill_r);
        res.word.last       = dump_last;
        if (out_free) begin
          res.ld = 1'b1;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = step;
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, count and request registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    val_r  <= val_nxt;
    ok_r   <= ok_nxt;
  end

  `ILIE_ASSERT_IMP(a_fill_cap, 1'b1, fill_r <= CNT_W'(CAPACITY), "fill count above capacity")
  `ILIE_ASSERT_IMP(a_shift_stop, state_r == S_SH_RD, idx_r != end_r, "shift started at stop index")
  `ILIE_ASSERT_IMP(a_dump_idx, state_r == S_DEMIT, idx_r <= end_r, "dump index past last entry")
  `ILIE_ASSERT_NXT(a_fill_hold, state_r != S_RESP, $stable(fill_r), "fill count moved outside response")

endmodule

// ===== design/ilie_out_reg.sv =====
// ----------------------------------------------------------------------------
// Indexed list output register
// Holds one result word for the downstream side and reports when it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilie_out_reg import ilie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_req_t  res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      valid_r;
  out_word_t data_r;

  // Free when empty or the held word leaves this cycle
  assign out_free = !valid_r || !out_stall;

  // Load a new word, drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.ld) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.ld) begin
      data_r <= res.word;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/indexed_list_insert_erase_top.sv =====
// ----------------------------------------------------------------------------
// Indexed list with insert, erase and dump
// Fixed-capacity ordered list of signed 32-bit values held in an entry RAM.
// ----------------------------------------------------------------------------
// One request word is taken at a time; in_stall stays high until its last
// result word has been loaded into the output register. Entries move one at
// a time: a RAM read in S_SH_RD, then a RAM write in S_SH_WR. A dump reads
// each entry in S_DRD and emits it in S_DEMIT, where stalls on the result
// side can hold it. A rejected request or a dump of an empty list goes
// straight to the response. The registered read of the entry RAM and its
// single read port set this order of steps. The RAM has no reset; length
// counts the valid entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_erase_top import ilie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             out_free;
  res_req_t         res;

  // Entry storage
  ilie_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request sequencer
  ilie_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .res       (res)
  );

  // Result word register
  ilie_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== bench/ilie_list_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed list result checker
// Watches both channels of the indexed list. It keeps its own copy of the
// list, works out the result words that each accepted request causes, and
// compares every accepted result word field by field against the oldest
// expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilie_list_checker import ilie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending,
  output int        words_in,
  output int        words_out,
  output int        dumps_seen
);

  localparam int REPORT_MAX = 10;

  // Shadow of the list contents and length
  logic signed [VAL_W-1:0] list_vals [CAPACITY];
  int                      list_len;
  out_word_t               expected_words [$];

  function automatic out_word_t result_word(logic ok, logic elem_ok,
                                            logic signed [VAL_W-1:0] value,
                                            logic is_last);
    out_word_t w;
    w            = '0;
    w.ok         = ok;
    w.elem_valid = elem_ok;
    w.elem_value = value;
    w.count_now  = COUNT_W'(list_len);
    w.last       = is_last;
    return w;
  endfunction

  // Apply one request to the shadow list and queue the words it causes
  task automatic apply_request(input in_word_t req);
    int  pos;
    int  i;
    logic ok;
    pos = $signed(req.position);
    ok  = 1'b0;
    case (req.req_type)
      REQ_INSERT: begin
        if (list_len < CAPACITY && pos >= 0 && pos <= list_len) begin
          for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = req.item_value;
          list_len++;
          ok = 1'b1;
        end
        expected_words.push_back(result_word(ok, 1'b0, '0, 1'b1));
      end
      REQ_ERASE: begin
        if (list_len > 0 && pos >= 0 && pos < list_len) begin
          for (i = pos + 1; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
          ok = 1'b1;
        end
        expected_words.push_back(result_word(ok, 1'b0, '0, 1'b1));
      end
      REQ_DUMP: begin
        dumps_seen++;
        if (list_len == 0) begin
          expected_words.push_back(result_word(1'b1, 1'b0, '0, 1'b1));
        end else begin
          for (i = 0; i < list_len; i++)
            expected_words.push_back(result_word(1'b1, 1'b1, list_vals[i],
                                                 i == list_len - 1));
        end
      end
      default: begin
        // Spare request code: rejected, list untouched
        expected_words.push_back(result_word(1'b0, 1'b0, '0, 1'b1));
      end
    endcase
  endtask

  // Compare one accepted result word with the oldest expectation
  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0t: result word with nothing expected: ok=%0b ev=%0b val=%h cnt=%0d last=%0b",
                 $time, got.ok, got.elem_valid, got.elem_value, got.count_now, got.last);
      return;
    end
    want = expected_words.pop_front();
    if (got.ok !== want.ok || got.elem_valid !== want.elem_valid ||
        got.elem_value !== want.elem_value || got.count_now !== want.count_now ||
        got.last !== want.last) begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("%0t: result word mismatch (word %0d)", $time, words_out);
        $display("  expected ok=%0b ev=%0b val=%h cnt=%0d last=%0b",
                 want.ok, want.elem_valid, want.elem_value, want.count_now, want.last);
        $display("  actual   ok=%0b ev=%0b val=%h cnt=%0d last=%0b",
                 got.ok, got.elem_valid, got.elem_value, got.count_now, got.last);
      end
    end
  endtask

  // Sample both channels at each edge; results come out only after their
  // request has been taken, so check before applying the new request
  always @(posedge clk) begin
    if (!rst_n) begin
      list_len   = 0;
      fail_count = 0;
      words_in   = 0;
      words_out  = 0;
      dumps_seen = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_word(out_data);
        words_out++;
      end
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        words_in++;
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/indexed_list_insert_erase_top_tb.sv =====
// ----------------------------------------------------------------------------
// Indexed list testbench
// Drives directed corner requests and then random insert, erase and dump
// phases into the list, with random idling on both sides, a calm stretch and
// one long result hold-off. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_erase_top_tb import ilie_pkg::*; ();

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int IDLE_PCT      = 37;
  localparam int RANDOM_ITEMS  = 260;
  localparam int PHASE_LEN     = 40;
  localparam int HOLD_AT       = 45;
  localparam int HOLD_CYCLES   = 240;
  localparam int DRAIN_CYCLES  = 80;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int        fail_count;
  int        pending;
  int        words_in;
  int        words_out;
  int        dumps_seen;

  // Stimulus-side view of the list length, used to aim positions and count full-list hits
  int        aim_len   = 0;
  int        full_hits = 0;
  logic      calm      = 1'b0;
  logic      hold_req  = 1'b0;
  logic      hold_done = 1'b0;

  indexed_list_insert_erase_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ilie_list_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .words_in   (words_in),
    .words_out  (words_out),
    .dumps_seen (dumps_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_word_t make_req(logic [1:0] kind, int pos,
                                        logic [VAL_W-1:0] value);
    in_word_t w;
    w.req_type   = kind;
    w.position   = POS_W'(pos);
    w.item_value = value;
    return w;
  endfunction

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input in_word_t w);
    int pos;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pos = $signed(w.position);
    if (w.req_type == REQ_INSERT && aim_len < CAPACITY && pos >= 0 && pos <= aim_len)
      aim_len++;
    else if (w.req_type == REQ_ERASE && pos >= 0 && pos < aim_len)
      aim_len--;
    if (aim_len == CAPACITY) full_hits++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions, the rest near misses and noise
  function automatic int pick_position(logic [1:0] kind);
    if ($urandom_range(0, 99) < 85) begin
      if (kind == REQ_INSERT) return $urandom_range(0, aim_len);
      if (aim_len > 0) return $urandom_range(0, aim_len - 1);
      return 0;
    end
    case ($urandom_range(0, 4))
      0:       return -1;
      1:       return (kind == REQ_INSERT) ? aim_len + 1 : aim_len;
      2:       return 32767;
      3:       return -32768;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic logic [1:0] pick_kind(int phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return REQ_SPARE;
    case (phase % 3)
      0:       return (roll < 67) ? REQ_INSERT : (roll < 85) ? REQ_ERASE : REQ_DUMP;
      1:       return (roll < 67) ? REQ_ERASE : (roll < 85) ? REQ_INSERT : REQ_DUMP;
      default: return (roll < 42) ? REQ_INSERT : (roll < 80) ? REQ_ERASE : REQ_DUMP;
    endcase
  endfunction

  // Result side: random stall, one long hold-off on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
          held++;
        end
        hold_done = 1'b1;
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Request side
  initial begin
    in_word_t   corner [$];
    logic [1:0] kind;
    int         j;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner requests: empty list, range edges, front, middle and back
    corner.push_back(make_req(REQ_DUMP,        0, 32'h0));
    corner.push_back(make_req(REQ_ERASE,       0, 32'h0));
    corner.push_back(make_req(REQ_INSERT,      1, 32'h5));
    corner.push_back(make_req(REQ_INSERT,     -1, 32'h5));
    corner.push_back(make_req(REQ_INSERT,      0, 32'h7fff_ffff));
    corner.push_back(make_req(REQ_INSERT,      0, 32'h8000_0000));
    corner.push_back(make_req(REQ_INSERT,      2, 32'h0));
    corner.push_back(make_req(REQ_INSERT,      1, 32'hffff_ffff));
    corner.push_back(make_req(REQ_INSERT,  32767, 32'h1));
    corner.push_back(make_req(REQ_INSERT, -32768, 32'h1));
    corner.push_back(make_req(REQ_INSERT,      4, 32'h5555_5555));
    corner.push_back(make_req(REQ_INSERT,      2, 32'haaaa_aaaa));
    corner.push_back(make_req(REQ_DUMP,    32767, 32'hffff_ffff));
    corner.push_back(make_req(REQ_ERASE,       6, 32'h0));
    corner.push_back(make_req(REQ_ERASE,  -32768, 32'h0));
    corner.push_back(make_req(REQ_ERASE,   32767, 32'h0));
    corner.push_back(make_req(REQ_SPARE,       3, 32'h5a5a_5a5a));
    corner.push_back(make_req(REQ_ERASE,       5, 32'h0));
    corner.push_back(make_req(REQ_ERASE,       0, 32'h0));
    corner.push_back(make_req(REQ_ERASE,       1, 32'h0));
    corner.push_back(make_req(REQ_DUMP,        0, 32'h0));
    corner.push_back(make_req(REQ_ERASE,       0, 32'h0));
    corner.push_back(make_req(REQ_ERASE,       0, 32'h0));
    corner.push_back(make_req(REQ_ERASE,       0, 32'h0));
    corner.push_back(make_req(REQ_DUMP,        0, 32'h0));
    foreach (corner[i]) send_word(corner[i]);

    // Random phases: grow, shrink, mixed; one phase with no idling
    for (j = 0; j < RANDOM_ITEMS; j++) begin
      calm = (j / PHASE_LEN == 3);
      if (j == HOLD_AT) begin
        hold_req = 1'b1;
        send_word(make_req(REQ_DUMP, 0, 32'h0));
      end
      kind = pick_kind(j / PHASE_LEN);
      send_word(make_req(kind, pick_position(kind), pick_value()));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Let the checker take the last request, drain, then wait for strays
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d request words (%0d dumps) and %0d result words;",
             words_in, dumps_seen, words_out);
    $display("the list was driven to full capacity on %0d requests.", full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
